/* rtl/kle_pkg.sv */
`timescale 1ns / 1ps

package kle_pkg;

  localparam int unsigned LineDepth    = 512;
  localparam int unsigned LineAw       = $clog2(LineDepth);
  localparam int unsigned CountW       = LineAw + 1;
  localparam int unsigned ConsoleCount = 12;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [3:0] TabCells    = 4'd8;
  localparam logic [3:0] OneCell     = 4'd1;

  localparam logic [7:0] KeyCtrl = 8'd0;
  localparam logic [7:0] KeyAlt  = 8'd1;
  localparam logic [7:0] KeyBksp = 8'd2;
  localparam logic [7:0] KeyF1   = 8'd3;
  localparam logic [7:0] KeyF12  = 8'd14;

  localparam logic OpKey  = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [1:0] KindChar    = 2'd0;
  localparam logic [1:0] KindSpecial = 2'd1;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_PERM = 2'd1,
    STS_INVALID = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_READ,
    CMD_NO_PERM,
    CMD_INVALID,
    CMD_CTRL,
    CMD_ALT,
    CMD_FKEY,
    CMD_CHAR,
    CMD_BKSP,
    CMD_IGNORE
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] key;
    logic       release_key;
  } cmd_t;

  // packed so that status sits in the lowest bits
  typedef struct packed {
    logic [7:0] read_char;
    logic       read_valid;
    logic       wake_reader;
    logic [3:0] switch_target;
    logic       switch_valid;
    logic [3:0] erase_count;
    logic [7:0] echo_char;
    logic       echo_valid;
    status_e    status;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_MEM
  } back_state_e;

endpackage

/* rtl/kle_ram.sv */
`timescale 1ns / 1ps

module kle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/kle_front.sv */
`timescale 1ns / 1ps

module kle_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          opcode_i,
  input  logic          caller_permitted_i,
  input  logic [1:0]    event_kind_i,
  input  logic [7:0]    key_code_i,
  input  logic          is_release_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output kle_pkg::cmd_t cmd_o
);
  import kle_pkg::*;

  cmd_t       cls;
  cmd_t       q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic [7:0] fkey_idx;

  assign fkey_idx = key_code_i - KeyF1;

  always_comb begin
    cls.key         = key_code_i;
    cls.release_key = is_release_i;
    if (opcode_i == OpRead) begin
      cls.kind = CMD_READ;
    end else if (!caller_permitted_i) begin
      cls.kind = CMD_NO_PERM;
    end else if (event_kind_i == KindChar) begin
      cls.kind = CMD_CHAR;
    end else if (event_kind_i != KindSpecial) begin
      cls.kind = CMD_INVALID;
    end else if (key_code_i == KeyCtrl) begin
      cls.kind = CMD_CTRL;
    end else if (key_code_i == KeyAlt) begin
      cls.kind = CMD_ALT;
    end else if (key_code_i == KeyBksp) begin
      cls.kind = CMD_BKSP;
    end else if (key_code_i >= KeyF1 && key_code_i <= KeyF12
                 && fkey_idx < 8'(ConsoleCount)) begin
      cls.kind = CMD_FKEY;
    end else begin
      cls.kind = CMD_IGNORE;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

/* rtl/kle_back.sv */
`timescale 1ns / 1ps

module kle_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  kle_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output kle_pkg::res_t res_o
);
  import kle_pkg::*;

  back_state_e       state_q, state_d;
  logic [LineAw-1:0] head_q, head_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [CountW-1:0] nl_q, nl_d;
  logic              ctrl_q, ctrl_d;
  logic              alt_q, alt_d;
  logic [3:0]        console_q, console_d;
  logic              waiting_q, waiting_d;
  logic              bksp_q, bksp_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;
  res_t              res;

  logic              ram_we, ram_re;
  logic [LineAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;
  logic [CountW-1:0] fill_dec;
  logic              active;

  assign fill_dec = fill_q - CountW'(1);
  assign active   = (console_q == 4'd0) && !cmd_i.release_key;
  assign cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i && (!out_valid_q || res_ready_i);

  kle_ram #(
    .Width (8),
    .Depth (LineDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    nl_d        = nl_q;
    ctrl_d      = ctrl_q;
    alt_d       = alt_q;
    console_d   = console_q;
    waiting_d   = waiting_q;
    bksp_d      = bksp_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    res         = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = head_q + fill_q[LineAw-1:0];
    ram_raddr   = head_q;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_pop_o) begin
          out_valid_d = 1'b1;
          unique case (cmd_i.kind)
            CMD_READ: begin
              if (nl_q != '0 && fill_q != '0) begin
                ram_re      = 1'b1;
                bksp_d      = 1'b0;
                out_valid_d = 1'b0;
                state_d     = BK_MEM;
              end else begin
                waiting_d = 1'b1;
              end
            end
            CMD_NO_PERM: res.status = STS_NO_PERM;
            CMD_INVALID: res.status = STS_INVALID;
            CMD_CTRL:    ctrl_d = !cmd_i.release_key;
            CMD_ALT:     alt_d  = !cmd_i.release_key;
            CMD_FKEY: begin
              if (ctrl_q && alt_q) begin
                console_d           = 4'(cmd_i.key - KeyF1);
                res.switch_valid    = 1'b1;
                res.switch_target   = 4'(cmd_i.key - KeyF1);
              end
            end
            CMD_CHAR: begin
              if (active) begin
                if (fill_q == CountW'(LineDepth)) begin
                  res.status = STS_FULL;
                end else begin
                  ram_we         = 1'b1;
                  fill_d         = fill_q + CountW'(1);
                  res.echo_valid = 1'b1;
                  res.echo_char  = cmd_i.key;
                  if (cmd_i.key == CharNewline) begin
                    nl_d = nl_q + CountW'(1);
                    if (waiting_q) begin
                      res.wake_reader = 1'b1;
                      waiting_d       = 1'b0;
                    end
                  end
                end
              end
            end
            CMD_BKSP: begin
              if (active && fill_q != '0) begin
                fill_d      = fill_dec;
                ram_re      = 1'b1;
                ram_raddr   = head_q + fill_dec[LineAw-1:0];
                bksp_d      = 1'b1;
                out_valid_d = 1'b0;
                state_d     = BK_MEM;
              end
            end
            CMD_IGNORE: ;
            default: ;
          endcase
          out_d = res;
        end
      end
      BK_MEM: begin
        if (ram_rdata == CharNewline && nl_q != '0) begin
          nl_d = nl_q - CountW'(1);
        end
        if (bksp_q) begin
          res.erase_count = (ram_rdata == CharTab) ? TabCells : OneCell;
        end else begin
          head_d         = head_q + LineAw'(1);
          fill_d         = fill_dec;
          res.read_valid = 1'b1;
          res.read_char  = ram_rdata;
        end
        out_d       = res;
        out_valid_d = 1'b1;
        state_d     = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      nl_q        <= '0;
      ctrl_q      <= 1'b0;
      alt_q       <= 1'b0;
      console_q   <= 4'd0;
      waiting_q   <= 1'b0;
      bksp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      nl_q        <= nl_d;
      ctrl_q      <= ctrl_d;
      alt_q       <= alt_d;
      console_q   <= console_d;
      waiting_q   <= waiting_d;
      bksp_q      <= bksp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CountW'(LineDepth)) else $error("fill count beyond depth");

  // a backspace lowers the fill count in the cycle before it lowers the newline count
  a_nl_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MEM && bksp_q) ? (nl_q <= fill_q + CountW'(1)) : (nl_q <= fill_q))
    else $error("more newlines than characters");

  a_mem_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_MEM |-> !out_valid_q) else $error("result register busy in memory step");

  a_mem_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_MEM |=> out_valid_q && state_q == BK_IDLE)
    else $error("memory step did not produce a result");

endmodule

/* rtl/keyboard_line_editor.sv */
`timescale 1ns / 1ps

// console line editor: key events and read requests come in on the slave stream, one
// result per transaction goes out on the master stream. a two-entry command queue sits
// between the decoder and the executing back end. key events, modifier changes, console
// switches and character appends finish in the back end's idle state; reads and
// backspaces that use the line memory also pass through the memory state, waiting
// for its registered read. the 512-byte line memory needs no clearing after reset.
module keyboard_line_editor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // caller_permitted, event_kind[1:0], key_code[7:0], is_release, zero pad
  input  logic [15:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], echo_valid, echo_char[7:0], erase_count[3:0], switch_valid,
  // switch_target[3:0], wake_reader, read_valid, read_char[7:0], zero pad
  output logic [31:0] m_axis_tdata
);
  import kle_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  kle_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .opcode_i           (s_axis_tuser),
    .caller_permitted_i (s_axis_tdata[0]),
    .event_kind_i       (s_axis_tdata[2:1]),
    .key_code_i         (s_axis_tdata[10:3]),
    .is_release_i       (s_axis_tdata[11]),
    .cmd_valid_o        (cmd_valid),
    .cmd_pop_i          (cmd_pop),
    .cmd_o              (cmd)
  );

  kle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

/* tb/kle_checker.sv */
`timescale 1ns / 1ps

module kle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  // caller_permitted, event_kind[1:0], key_code[7:0], is_release, zero pad
  input  logic [15:0] in_tdata_i,
  // opcode
  input  logic        in_tuser_i,
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  // status[1:0], echo_valid, echo_char[7:0], erase_count[3:0], switch_valid,
  // switch_target[3:0], wake_reader, read_valid, read_char[7:0], zero pad
  input  logic [31:0] out_tdata_i,
  output int          pending_o,
  output int          fail_count_o
);
  import kle_pkg::*;

  logic [7:0]        line_mem [LineDepth];
  logic [LineAw-1:0] oldest_pos    = '0;
  logic [CountW-1:0] char_count    = '0;
  logic [CountW-1:0] newline_total = '0;
  logic              ctrl_down     = 1'b0;
  logic              alt_down      = 1'b0;
  logic [3:0]        console_sel   = '0;
  logic              reader_pending = 1'b0;

  res_t expected_results [$];
  int   result_idx = 0;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  function automatic res_t line_editor_result(input logic op, input logic perm,
                                              input logic [1:0] kind, input logic [7:0] key,
                                              input logic rel);
    res_t              r;
    logic              handled;
    logic [7:0]        c;
    logic [7:0]        fkey_idx;
    logic [LineAw-1:0] pos;
    r = '0;
    handled = 1'b0;
    fkey_idx = key - KeyF1;
    if (op == OpRead) begin
      if (newline_total != '0 && char_count != '0) begin
        c = line_mem[oldest_pos];
        oldest_pos = oldest_pos + 1'b1;
        char_count = char_count - 1'b1;
        if (c == CharNewline) newline_total = newline_total - 1'b1;
        r.read_valid = 1'b1;
        r.read_char  = c;
      end else begin
        reader_pending = 1'b1;
      end
    end else if (!perm) begin
      r.status = STS_NO_PERM;
    end else if (kind != KindChar && kind != KindSpecial) begin
      r.status = STS_INVALID;
    end else begin
      if (kind == KindSpecial) begin
        if (key == KeyCtrl) begin
          ctrl_down = !rel;
          handled = 1'b1;
        end else if (key == KeyAlt) begin
          alt_down = !rel;
          handled = 1'b1;
        end else if (ctrl_down && alt_down && key >= KeyF1 && key <= KeyF12 &&
                     fkey_idx < 8'(ConsoleCount)) begin
          console_sel = fkey_idx[3:0];
          r.switch_valid  = 1'b1;
          r.switch_target = console_sel;
          handled = 1'b1;
        end
      end
      if (!handled && console_sel == 4'd0 && !rel) begin
        if (kind == KindChar) begin
          if (char_count >= CountW'(LineDepth)) begin
            r.status = STS_FULL;
          end else begin
            pos = oldest_pos + char_count[LineAw-1:0];
            line_mem[pos] = key;
            char_count = char_count + 1'b1;
            r.echo_valid = 1'b1;
            r.echo_char  = key;
            if (key == CharNewline) begin
              newline_total = newline_total + 1'b1;
              if (reader_pending) begin
                r.wake_reader = 1'b1;
                reader_pending = 1'b0;
              end
            end
          end
        end else if (key == KeyBksp && char_count != '0) begin
          char_count = char_count - 1'b1;
          pos = oldest_pos + char_count[LineAw-1:0];
          c = line_mem[pos];
          if (c == CharNewline && newline_total != '0) newline_total = newline_total - 1'b1;
          r.erase_count = (c == CharTab) ? TabCells : OneCell;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count_o++;
    $display("%0t ns result %0d: %s got %0d want %0d", $time, result_idx, what, got, want);
  endtask

  always @(posedge clk_i) begin
    res_t got_res;
    res_t want_res;
    if (rst_ni) begin
      if (out_tvalid_i && out_tready_i) begin
        got_res = res_t'(out_tdata_i[29:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", int'(out_tdata_i), 0);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.status != want_res.status)
            report_mismatch("status", int'(got_res.status), int'(want_res.status));
          if (got_res.echo_valid != want_res.echo_valid)
            report_mismatch("echo_valid", int'(got_res.echo_valid),
                            int'(want_res.echo_valid));
          if (got_res.echo_char != want_res.echo_char)
            report_mismatch("echo_char", int'(got_res.echo_char), int'(want_res.echo_char));
          if (got_res.erase_count != want_res.erase_count)
            report_mismatch("erase_count", int'(got_res.erase_count),
                            int'(want_res.erase_count));
          if (got_res.switch_valid != want_res.switch_valid)
            report_mismatch("switch_valid", int'(got_res.switch_valid),
                            int'(want_res.switch_valid));
          if (got_res.switch_target != want_res.switch_target)
            report_mismatch("switch_target", int'(got_res.switch_target),
                            int'(want_res.switch_target));
          if (got_res.wake_reader != want_res.wake_reader)
            report_mismatch("wake_reader", int'(got_res.wake_reader),
                            int'(want_res.wake_reader));
          if (got_res.read_valid != want_res.read_valid)
            report_mismatch("read_valid", int'(got_res.read_valid),
                            int'(want_res.read_valid));
          if (got_res.read_char != want_res.read_char)
            report_mismatch("read_char", int'(got_res.read_char), int'(want_res.read_char));
        end
        result_idx++;
      end
      if (in_tvalid_i && in_tready_i) begin
        expected_results.push_back(line_editor_result(in_tuser_i, in_tdata_i[0],
                                                      in_tdata_i[2:1], in_tdata_i[10:3],
                                                      in_tdata_i[11]));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import kle_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // caller_permitted, event_kind[1:0], key_code[7:0], is_release, zero pad
  logic [15:0] s_axis_tdata  = '0;
  // opcode
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[1:0], echo_valid, echo_char[7:0], erase_count[3:0], switch_valid,
  // switch_target[3:0], wake_reader, read_valid, read_char[7:0], zero pad
  logic [31:0] m_axis_tdata;

  int pending;
  int fail_count;
  int tx_max_gap   = 16;
  int rx_max_stall = 16;

  keyboard_line_editor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  kle_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_i (s_axis_tready),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_tvalid_i(m_axis_tvalid),
    .out_tready_i(m_axis_tready),
    .out_tdata_i (m_axis_tdata),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(input logic op, input logic perm, input logic [1:0] kind,
                           input logic [7:0] key, input logic rel);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, rel, key, kind, perm};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_key(input logic [1:0] kind, input logic [7:0] key, input logic rel);
    send_item(OpKey, 1'b1, kind, key, rel);
  endtask

  // other fields are don't-care on a read, so they get random values
  task automatic send_read();
    send_item(OpRead, 1'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_random_action();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(0, 9);
      if (n < 7) c = 8'($urandom_range(32, 126));
      else if (n < 8) c = CharTab;
      else c = 8'($urandom);
      send_key(KindChar, c, 1'b0);
    end else if (pick < 48) begin
      send_key(KindChar, CharNewline, 1'b0);
    end else if (pick < 58) begin
      send_key(KindSpecial, KeyBksp, 1'b0);
    end else if (pick < 72) begin
      send_read();
    end else if (pick < 78) begin
      // switch away and back to console 0
      send_key(KindSpecial, KeyCtrl, 1'b0);
      send_key(KindSpecial, KeyAlt, 1'b0);
      send_key(KindSpecial, 8'($urandom_range(KeyF1, KeyF12)), 1'($urandom));
      n = $urandom_range(0, 3);
      repeat (n) send_key(KindChar, 8'($urandom), 1'b0);
      send_key(KindSpecial, KeyBksp, 1'b0);
      send_key(KindSpecial, KeyF1, 1'($urandom));
      if ($urandom_range(0, 1)) begin
        send_key(KindSpecial, KeyAlt, 1'b1);
        send_key(KindSpecial, KeyCtrl, 1'b1);
      end else begin
        send_key(KindSpecial, KeyCtrl, 1'b1);
        send_key(KindSpecial, KeyAlt, 1'b1);
      end
    end else if (pick < 84) begin
      send_key(KindSpecial, $urandom_range(0, 1) ? KeyAlt : KeyCtrl, 1'($urandom));
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) send_key(KindChar, 8'($urandom), 1'b1);
      else send_key(KindSpecial, 8'($urandom), 1'($urandom));
    end else begin
      send_item(1'($urandom), 1'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // result side: random stalls, two long hold-offs to back up the block
  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      if (taken == 40 || taken == 800) stall = 300;
      else stall = $urandom_range(0, rx_max_stall);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin
    int         wait_cycles;
    logic [7:0] c;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part
    send_item(OpKey, 1'b0, KindChar, 8'h61, 1'b0);
    send_item(OpKey, 1'b1, 2'd2, 8'h00, 1'b0);
    send_item(OpKey, 1'b1, 2'd3, 8'hFF, 1'b1);
    send_item(OpRead, 1'b1, 2'd3, 8'hFF, 1'b1);
    send_key(KindChar, 8'h00, 1'b0);
    send_key(KindChar, 8'hFF, 1'b0);
    send_key(KindChar, CharTab, 1'b0);
    send_key(KindSpecial, KeyBksp, 1'b0);
    send_key(KindChar, 8'h78, 1'b1);
    send_key(KindChar, CharNewline, 1'b0);
    send_key(KindChar, CharNewline, 1'b0);
    send_key(KindSpecial, KeyBksp, 1'b0);
    send_key(KindSpecial, 8'd15, 1'b0);
    send_key(KindSpecial, KeyBksp, 1'b1);
    send_key(KindSpecial, KeyF1, 1'b0);
    send_key(KindSpecial, KeyCtrl, 1'b0);
    send_key(KindSpecial, KeyAlt, 1'b0);
    send_key(KindSpecial, KeyF12, 1'b0);
    send_key(KindChar, 8'h62, 1'b0);
    send_key(KindSpecial, KeyBksp, 1'b0);
    send_key(KindSpecial, KeyF1, 1'b1);
    send_key(KindSpecial, KeyCtrl, 1'b1);
    send_key(KindSpecial, KeyAlt, 1'b1);
    repeat (4) send_read();

    // random editing
    repeat (100) send_random_action();

    // back to console 0, then overflow the line buffer
    send_key(KindSpecial, KeyCtrl, 1'b0);
    send_key(KindSpecial, KeyAlt, 1'b0);
    send_key(KindSpecial, KeyF1, 1'b0);
    send_key(KindSpecial, KeyAlt, 1'b1);
    send_key(KindSpecial, KeyCtrl, 1'b1);
    tx_max_gap   = 0;
    rx_max_stall = 0;
    for (int i = 0; i < 515; i++) begin
      if (i == 200) begin
        tx_max_gap   = 16;
        rx_max_stall = 16;
      end
      do c = 8'($urandom); while (c == CharNewline);
      send_key(KindChar, c, 1'b0);
    end
    send_key(KindSpecial, KeyBksp, 1'b0);
    send_key(KindChar, CharNewline, 1'b0);
    repeat (515) send_read();

    repeat (40) send_random_action();

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/kle_pkg.sv
rtl/kle_ram.sv
rtl/kle_front.sv
rtl/kle_back.sv
rtl/keyboard_line_editor.sv
tb/kle_checker.sv
tb/tb_top.sv
